FILE: hdl/abf_pkg.sv
// ----------------------------------------------------------------------------
// abf_pkg: shared types and constants for the attenuated Bloom filter
// Operation codes, cell command struct, hash mask, popcount and the
// element estimate table.
// ----------------------------------------------------------------------------
package abf_pkg;

    localparam int WORD_W  = 64;
    localparam int HASH_W  = 16;
    localparam int KIND_W  = 3;
    localparam int LEVEL_W = 2;
    localparam int CNT_W   = 7;
    localparam int EST_W   = 8;
    localparam int TOT_W   = 10;
    localparam int TOTAL_MAX = 1023;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD   = 3'd0,
        KIND_CHECK = 3'd1,
        KIND_ATTEN = 3'd2,
        KIND_MERGE = 3'd3,
        KIND_CLEAR = 3'd4
    } kind_t;

    typedef struct packed {
        logic              load;
        logic [KIND_W-1:0] kind;
        logic [WORD_W-1:0] mask;
        logic [WORD_W-1:0] merge_word;
    } cell_cmd_t;

    // floor(-32*ln(1-X/64)), X = 64 saturates
    localparam logic [EST_W-1:0] EST_TABLE [0:64] = '{
        8'd0,   8'd0,   8'd1,   8'd1,   8'd2,   8'd2,   8'd3,   8'd3,
        8'd4,   8'd4,   8'd5,   8'd6,   8'd6,   8'd7,   8'd7,   8'd8,
        8'd9,   8'd9,   8'd10,  8'd11,  8'd11,  8'd12,  8'd13,  8'd14,
        8'd15,  8'd15,  8'd16,  8'd17,  8'd18,  8'd19,  8'd20,  8'd21,
        8'd22,  8'd23,  8'd24,  8'd25,  8'd26,  8'd27,  8'd28,  8'd30,
        8'd31,  8'd32,  8'd34,  8'd35,  8'd37,  8'd38,  8'd40,  8'd42,
        8'd44,  8'd46,  8'd48,  8'd51,  8'd53,  8'd56,  8'd59,  8'd62,
        8'd66,  8'd70,  8'd75,  8'd81,  8'd88,  8'd97,  8'd110, 8'd133,
        8'd255
    };

    function automatic logic [WORD_W-1:0] hash_mask(input logic [HASH_W-1:0] h);
        logic [WORD_W-1:0] m;
        m = '0;
        m[h[5:0]]  = 1'b1;
        m[h[11:6]] = 1'b1;
        return m;
    endfunction

    function automatic logic [3:0] pop8(input logic [7:0] b);
        logic [3:0] c;
        c = '0;
        for (int i = 0; i < 8; i++)
        begin
            c = c + 4'(b[i]);
        end
        return c;
    endfunction

    function automatic logic [CNT_W-1:0] popcount64(input logic [WORD_W-1:0] w);
        logic [CNT_W-1:0] c;
        c = '0;
        for (int i = 0; i < 8; i++)
        begin
            c = c + CNT_W'(pop8(w[8*i +: 8]));
        end
        return c;
    endfunction

endpackage

FILE: hdl/abf_if.sv
// ----------------------------------------------------------------------------
// abf_if: valid/ready channels of the attenuated Bloom filter
// Command channel carries one operation word, response channel one result.
// ----------------------------------------------------------------------------
interface abf_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [1:0]  level;
    logic [15:0] hash;
    logic [63:0] merge_word;

    modport source (output valid, kind, level, hash, merge_word, input ready);
    modport sink   (input valid, kind, level, hash, merge_word, output ready);
endinterface

interface abf_rsp_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [1:0]  found_level;
    logic [63:0] level_bits;
    logic [7:0]  level_estimate;
    logic [9:0]  total_estimate;
    logic        all_empty;

    modport source (output valid, found, found_level, level_bits, level_estimate,
                    total_estimate, all_empty, input ready);
    modport sink   (input valid, found, found_level, level_bits, level_estimate,
                    total_estimate, all_empty, output ready);
endinterface

FILE: hdl/abf_cell.sv
// ----------------------------------------------------------------------------
// abf_cell: one filter level
// Holds one level word, takes the shallower neighbor's word on attenuate,
// and registers its own element estimate every cycle.
// ----------------------------------------------------------------------------
module abf_cell
    import abf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cell_cmd_t         cmd,
    input  logic              sel,
    input  logic [WORD_W-1:0] shift_in,
    output logic [WORD_W-1:0] word,
    output logic [EST_W-1:0]  est,
    output logic              nonzero,
    output logic              hit
);

    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] word_next;
    logic [EST_W-1:0]  est_reg;

    always_comb
    begin
        word_next = word_reg;
        if (cmd.load)
        begin
            case (cmd.kind)
                KIND_ADD:   if (sel) word_next = word_reg | cmd.mask;
                KIND_ATTEN: word_next = shift_in;
                KIND_MERGE: if (sel) word_next = word_reg | cmd.merge_word;
                KIND_CLEAR: word_next = '0;
                default:    word_next = word_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg <= '0;
            est_reg  <= '0;
        end
        else
        begin
            word_reg <= word_next;
            est_reg  <= EST_TABLE[popcount64(word_reg)];
        end
    end

    assign word    = word_reg;
    assign est     = est_reg;
    assign nonzero = |word_reg;
    assign hit     = ((word_reg & cmd.mask) == cmd.mask);

endmodule

FILE: hdl/attenuated_bloom_filter.sv
// ----------------------------------------------------------------------------
// attenuated_bloom_filter: multi-level Bloom filter with attenuation
// A row of level cells; attenuate moves every word one cell deeper.
//
//   channel | dir | words
//   --------+-----+--------------------------------------------------
//   cmd     | in  | kind, level, hash, merge_word
//   rsp     | out | found, found_level, level_bits, estimates, empty
//   cfg     | in  | self_hash, write enable only
//
// A word passes from accept to response valid through cell update,
// per-cell popcount and table lookup, then sum and select. cmd.ready is
// high only while no word is in flight: a new word is taken only once the
// last response is taken. Reset clears all level words and self_hash.
// A stalled response holds its word and blocks cmd.
// ----------------------------------------------------------------------------
module attenuated_bloom_filter
    import abf_pkg::*;
#(
    parameter int NUM_LEVELS = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    abf_cmd_if.sink    cmd,
    abf_rsp_if.source  rsp,
    input  logic       cfg_we,
    input  logic [15:0] cfg_wdata
);

    localparam int RAW_W = $clog2(NUM_LEVELS * 255 + 1);
    localparam int SUM_W = (RAW_W > TOT_W) ? RAW_W : TOT_W;

    typedef enum logic [1:0] {S_IDLE, S_EST, S_SUM, S_OUT} state_t;

    state_t              state_reg;
    logic [HASH_W-1:0]   self_hash_reg;
    logic [LEVEL_W-1:0]  level_reg;
    logic                found_reg;
    logic [LEVEL_W-1:0]  found_level_reg;
    logic [WORD_W-1:0]   level_bits_reg;
    logic [EST_W-1:0]    level_est_reg;
    logic [TOT_W-1:0]    total_reg;
    logic                empty_reg;

    cell_cmd_t           cell_cmd;
    logic                accept;
    logic [WORD_W-1:0]   words [NUM_LEVELS];
    logic [EST_W-1:0]    ests  [NUM_LEVELS];
    logic [NUM_LEVELS-1:0] nonzero;
    logic [NUM_LEVELS-1:0] hits;

    logic                found_next;
    logic [LEVEL_W-1:0]  found_level_next;
    logic [WORD_W-1:0]   sel_word;
    logic [EST_W-1:0]    sel_est;
    logic [SUM_W-1:0]    est_sum;
    logic [TOT_W-1:0]    total_next;

    assign accept    = cmd.valid && cmd.ready;
    assign cmd.ready = (state_reg == S_IDLE);

    assign cell_cmd.load       = accept;
    assign cell_cmd.kind       = cmd.kind;
    assign cell_cmd.mask       = hash_mask(cmd.hash);
    assign cell_cmd.merge_word = cmd.merge_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            self_hash_reg <= '0;
        else if (cfg_we)
            self_hash_reg <= cfg_wdata;
    end

    for (genvar g = 0; g < NUM_LEVELS; g++)
    begin : g_cell
        logic [WORD_W-1:0] shift_in;
        if (g == 0)
        begin : g_head
            assign shift_in = hash_mask(self_hash_reg);
        end
        else
        begin : g_link
            assign shift_in = words[g-1];
        end

        abf_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cmd      (cell_cmd),
            .sel      (int'(cmd.level) == g),
            .shift_in (shift_in),
            .word     (words[g]),
            .est      (ests[g]),
            .nonzero  (nonzero[g]),
            .hit      (hits[g])
        );
    end

    // lowest hitting level wins
    always_comb
    begin
        found_next       = 1'b0;
        found_level_next = '0;
        if (cmd.kind == KIND_CHECK)
        begin
            for (int i = NUM_LEVELS - 1; i >= 0; i--)
            begin
                if (hits[i])
                begin
                    found_next       = 1'b1;
                    found_level_next = LEVEL_W'(i);
                end
            end
        end
    end

    always_comb
    begin
        sel_word = '0;
        sel_est  = '0;
        est_sum  = '0;
        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            est_sum = est_sum + SUM_W'(ests[i]);
            if (int'(level_reg) == i)
            begin
                sel_word = words[i];
                sel_est  = ests[i];
            end
        end
        if (est_sum > SUM_W'(TOTAL_MAX))
            total_next = TOT_W'(TOTAL_MAX);
        else
            total_next = est_sum[TOT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            level_reg       <= '0;
            found_reg       <= 1'b0;
            found_level_reg <= '0;
            level_bits_reg  <= '0;
            level_est_reg   <= '0;
            total_reg       <= '0;
            empty_reg       <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg       <= S_EST;
                        level_reg       <= cmd.level;
                        found_reg       <= found_next;
                        found_level_reg <= found_level_next;
                    end
                end
                S_EST:
                begin
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    state_reg      <= S_OUT;
                    level_bits_reg <= sel_word;
                    level_est_reg  <= sel_est;
                    total_reg      <= total_next;
                    empty_reg      <= ~|nonzero;
                end
                S_OUT:
                begin
                    if (rsp.ready)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid          = (state_reg == S_OUT);
    assign rsp.found          = found_reg;
    assign rsp.found_level    = found_level_reg;
    assign rsp.level_bits     = level_bits_reg;
    assign rsp.level_estimate = level_est_reg;
    assign rsp.total_estimate = total_reg;
    assign rsp.all_empty      = empty_reg;

`ifndef NO_ASSERTIONS
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !cmd.ready)
        else $error("command accepted while a response is pending");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready) |-> ##3 rsp.valid)
        else $error("response not valid three cycles after accept");

    a_found_level: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.found) |-> (rsp.found_level == '0))
        else $error("found_level set without a hit");
`endif

endmodule
